[src/stc_pkg.sv]
// Package for the seconds-to-calendar splitter: operand codes of the shared
// subtract unit, fixed divisors and small calendar helper functions.
// No dependencies.
package stc_pkg;

  localparam int SECONDS_WIDTH_DEF = 34;

  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN = 6'd60;
  localparam logic [8:0]  YEARS_PER_ERA = 9'd400;
  localparam logic [24:0] SECS_PER_YEAR = 25'd31536000;
  localparam logic [24:0] SECS_PER_LEAP_YEAR = 25'd31622400;
  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_DEC = 4'd12;

  // configuration register indexes
  localparam logic CFG_EPOCH_YEAR = 1'b0;
  localparam logic CFG_ZONE_OFFSET = 1'b1;

  // operand select of the shared subtract unit
  typedef enum logic [2:0] {
    OP_ERA  = 3'd0,
    OP_DAY  = 3'd1,
    OP_HOUR = 3'd2,
    OP_MIN  = 3'd3,
    OP_VAR  = 3'd4
  } stc_op_t;

  // x mod 7 by folding 3-bit digits (8 = 1 mod 7)
  function automatic logic [2:0] mod7(input logic [10:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[10:9]);
    s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

  function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    s = 4'(a) + 4'(b);
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

  // leap test on the year modulo 400
  function automatic logic is_leap(input logic [8:0] ymod);
    logic century;
    century = (ymod == 9'd100) || (ymod == 9'd200) || (ymod == 9'd300);
    return (ymod[1:0] == 2'b00) && !century;
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
    logic [4:0] len;
    if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else if (month == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

  // seconds in a month of the given length in days
  function automatic logic [21:0] month_secs(input logic [4:0] len);
    logic [21:0] s;
    case (len)
      5'd28:   s = 22'd2419200;
      5'd29:   s = 22'd2505600;
      5'd30:   s = 22'd2592000;
      default: s = 22'd2678400;
    endcase
    return s;
  endfunction

  // weekday (0 Monday) of January 1 of a year given modulo 400
  function automatic logic [2:0] jan1_wday(input logic [8:0] ymod);
    logic [9:0]  y;
    logic [2:0]  q100;
    logic [10:0] s;
    y = 10'(ymod) + 10'd399;
    q100 = 3'd3 + 3'(y >= 10'd400) + 3'(y >= 10'd500) + 3'(y >= 10'd600)
         + 3'(y >= 10'd700);
    s = 11'(y) + 11'(y[9:2]) - 11'(q100) + 11'(y >= 10'd400);
    return mod7(s);
  endfunction

endpackage

[src/stc_alu.sv]
// Shared subtract and compare unit of the seconds-to-calendar splitter.
// Selects the fixed divisor or a variable operand; depends on stc_pkg.
module stc_alu import stc_pkg::*; #(
  parameter int UW = 35
) (
  input  stc_op_t       op,
  input  logic [UW-1:0] a,
  input  logic [UW-1:0] var_b,
  output logic [UW-1:0] diff,
  output logic          ge
);

  logic [UW-1:0] b;
  logic [UW:0]   d;

  always_comb begin
    case (op)
      OP_ERA:  b = UW'(YEARS_PER_ERA);
      OP_DAY:  b = UW'(SECS_PER_DAY);
      OP_HOUR: b = UW'(SECS_PER_HOUR);
      OP_MIN:  b = UW'(SECS_PER_MIN);
      OP_VAR:  b = var_b;
      default: b = var_b;
    endcase
  end

  assign d    = {1'b0, a} - {1'b0, b};
  assign ge   = !d[UW];
  assign diff = d[UW-1:0];

endmodule

[src/seconds_to_calendar_split_top.sv]
// Top level of the seconds-to-calendar splitter: sequencer, working registers
// and output register around one shared subtract unit.
// Depends on stc_pkg and stc_alu.
//
// Usage: a seconds count since January 1 of epoch_year enters on the in_
// channel (valid/ready); one calendar result leaves on the out_ channel.
// cfg_we with cfg_index writes epoch_year (index 0) or zone_offset_hours
// (index 1, signed hours) from cfg_wdata; write only while idle.
// One transaction is worked on at a time; in_ready is high only when idle.
// Each step (era reduction, then the year, month, day, hour and minute loops)
// uses the one shared subtractor; for 34-bit counts the year loop dominates.
// The finished result sits in an output register; if the receiver stalls,
// the block still takes the next transaction and only waits at the end of
// that one until the register is free. Synchronous reset (rst_n low) clears
// the sequencer and output valid and sets epoch_year 1970, offset 0.
module seconds_to_calendar_split_top import stc_pkg::*; #(
  parameter int SECONDS_WIDTH = SECONDS_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [11:0]              cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SECONDS_WIDTH-1:0] in_seconds_count,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [11:0]              out_year,
  output logic [3:0]               out_month,
  output logic [4:0]               out_day_of_month,
  output logic [8:0]               out_day_of_year,
  output logic [4:0]               out_hour,
  output logic [5:0]               out_minute,
  output logic [5:0]               out_second,
  output logic [2:0]               out_weekday
);

  localparam int TW = SECONDS_WIDTH + 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ERA   = 8'b0000_0010,
    S_YEAR  = 8'b0000_0100,
    S_MONTH = 8'b0000_1000,
    S_DAY   = 8'b0001_0000,
    S_HOUR  = 8'b0010_0000,
    S_MIN   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [11:0]       epoch_r, epoch_nxt;
  logic signed [4:0] zone_r, zone_nxt;

  logic [TW-1:0] t_r, t_nxt;
  logic [4:0]    day_r, day_nxt;
  logic [11:0]   ymod_r, ymod_nxt;
  logic [11:0]   year_r, year_nxt;
  logic [3:0]    month_r, month_nxt;
  logic [8:0]    yday_r, yday_nxt;
  logic [4:0]    hour_r, hour_nxt;
  logic [5:0]    min_r, min_nxt;
  logic [5:0]    sec_r, sec_nxt;
  logic [2:0]    wd_r, wd_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [11:0] out_year_r, out_year_nxt;
  logic [3:0]  out_month_r, out_month_nxt;
  logic [4:0]  out_dom_r, out_dom_nxt;
  logic [8:0]  out_doy_r, out_doy_nxt;
  logic [4:0]  out_hour_r, out_hour_nxt;
  logic [5:0]  out_min_r, out_min_nxt;
  logic [5:0]  out_sec_r, out_sec_nxt;
  logic [2:0]  out_wd_r, out_wd_nxt;

  stc_op_t       alu_op;
  logic [TW-1:0] alu_a;
  logic [TW-1:0] alu_b;
  logic [TW-1:0] alu_diff;
  logic          alu_ge;

  logic signed [16:0] off_sec;
  logic signed [TW:0] sum;
  logic [TW-1:0]      t_load;
  logic               leap;
  logic [4:0]         mlen;

  stc_alu #(.UW(TW)) u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .var_b(alu_b),
    .diff (alu_diff),
    .ge   (alu_ge)
  );

  assign off_sec = 17'(zone_r) * 17'sd3600;
  assign sum     = $signed({2'b00, in_seconds_count}) + (TW + 1)'(off_sec);
  assign t_load  = sum[TW] ? '0 : sum[TW-1:0];
  assign leap    = is_leap(ymod_r[8:0]);
  assign mlen    = month_len(leap, month_r);

  always_comb begin
    state_nxt     = state_r;
    epoch_nxt     = epoch_r;
    zone_nxt      = zone_r;
    t_nxt         = t_r;
    day_nxt       = day_r;
    ymod_nxt      = ymod_r;
    year_nxt      = year_r;
    month_nxt     = month_r;
    yday_nxt      = yday_r;
    hour_nxt      = hour_r;
    min_nxt       = min_r;
    sec_nxt       = sec_r;
    wd_nxt        = wd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_year_nxt  = out_year_r;
    out_month_nxt = out_month_r;
    out_dom_nxt   = out_dom_r;
    out_doy_nxt   = out_doy_r;
    out_hour_nxt  = out_hour_r;
    out_min_nxt   = out_min_r;
    out_sec_nxt   = out_sec_r;
    out_wd_nxt    = out_wd_r;
    alu_op        = OP_VAR;
    alu_a         = '0;
    alu_b         = '0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_EPOCH_YEAR:  epoch_nxt = cfg_wdata;
        CFG_ZONE_OFFSET: zone_nxt = $signed(cfg_wdata[4:0]);
        default:         epoch_nxt = epoch_r;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          t_nxt     = t_load;
          day_nxt   = '0;
          ymod_nxt  = epoch_r;
          year_nxt  = epoch_r;
          yday_nxt  = '0;
          hour_nxt  = '0;
          min_nxt   = '0;
          state_nxt = S_ERA;
        end
      end
      S_ERA: begin
        alu_op = OP_ERA;
        alu_a  = TW'(ymod_r);
        if (alu_ge) begin
          ymod_nxt = alu_diff[11:0];
        end else begin
          wd_nxt    = jan1_wday(ymod_r[8:0]);
          state_nxt = S_YEAR;
        end
      end
      S_YEAR: begin
        alu_op = OP_VAR;
        alu_a  = t_r;
        alu_b  = leap ? TW'(SECS_PER_LEAP_YEAR) : TW'(SECS_PER_YEAR);
        if (alu_ge) begin
          t_nxt    = alu_diff;
          year_nxt = year_r + 1'b1;
          ymod_nxt = (ymod_r == 12'd399) ? '0 : ymod_r + 1'b1;
          wd_nxt   = add_mod7(wd_r, leap ? 3'd2 : 3'd1);
        end else begin
          month_nxt = MONTH_JAN;
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        alu_op = OP_VAR;
        alu_a  = t_r;
        alu_b  = TW'(month_secs(mlen));
        if (alu_ge && month_r != MONTH_DEC) begin
          t_nxt     = alu_diff;
          month_nxt = month_r + 1'b1;
          yday_nxt  = yday_r + 9'(mlen);
          wd_nxt    = add_mod7(wd_r, mod7(11'(mlen)));
        end else begin
          state_nxt = S_DAY;
        end
      end
      S_DAY: begin
        alu_op = OP_DAY;
        alu_a  = t_r;
        if (alu_ge) begin
          t_nxt    = alu_diff;
          day_nxt  = day_r + 1'b1;
          yday_nxt = yday_r + 1'b1;
        end else begin
          state_nxt = S_HOUR;
        end
      end
      S_HOUR: begin
        alu_op = OP_HOUR;
        alu_a  = t_r;
        if (alu_ge) begin
          t_nxt    = alu_diff;
          hour_nxt = hour_r + 1'b1;
        end else begin
          state_nxt = S_MIN;
        end
      end
      S_MIN: begin
        alu_op = OP_MIN;
        alu_a  = t_r;
        if (alu_ge) begin
          t_nxt   = alu_diff;
          min_nxt = min_r + 1'b1;
        end else begin
          sec_nxt   = t_r[5:0];
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_year_nxt  = year_r;
          out_month_nxt = month_r;
          out_dom_nxt   = day_r + 5'd1;
          out_doy_nxt   = yday_r;
          out_hour_nxt  = hour_r;
          out_min_nxt   = min_r;
          out_sec_nxt   = sec_r;
          out_wd_nxt    = add_mod7(wd_r, mod7(11'(day_r)));
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      epoch_r     <= 12'd1970;
      zone_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      epoch_r     <= epoch_nxt;
      zone_r      <= zone_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r         <= t_nxt;
    day_r       <= day_nxt;
    ymod_r      <= ymod_nxt;
    year_r      <= year_nxt;
    month_r     <= month_nxt;
    yday_r      <= yday_nxt;
    hour_r      <= hour_nxt;
    min_r       <= min_nxt;
    sec_r       <= sec_nxt;
    wd_r        <= wd_nxt;
    out_year_r  <= out_year_nxt;
    out_month_r <= out_month_nxt;
    out_dom_r   <= out_dom_nxt;
    out_doy_r   <= out_doy_nxt;
    out_hour_r  <= out_hour_nxt;
    out_min_r   <= out_min_nxt;
    out_sec_r   <= out_sec_nxt;
    out_wd_r    <= out_wd_nxt;
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_year         = out_year_r;
  assign out_month        = out_month_r;
  assign out_day_of_month = out_dom_r;
  assign out_day_of_year  = out_doy_r;
  assign out_hour         = out_hour_r;
  assign out_minute       = out_min_r;
  assign out_second       = out_sec_r;
  assign out_weekday      = out_wd_r;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_min_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MIN) |-> (t_r < TW'(SECS_PER_HOUR)) && (hour_r < 5'd24))
    else $error("hour split left too large a remainder");

  a_era_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_YEAR || state_r == S_MONTH) |-> (ymod_r < 12'd400) && (wd_r < 3'd7))
    else $error("year modulo 400 or weekday out of range");

  a_month_secs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MONTH) |-> (t_r < TW'(SECS_PER_LEAP_YEAR)) && (month_r >= MONTH_JAN)
      && (month_r <= MONTH_DEC))
    else $error("month walk out of range");

  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOUR) |-> (t_r < TW'(SECS_PER_DAY)) && (day_r < 5'd31)
      && (yday_r < 9'd366))
    else $error("day walk out of range");

  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && (!out_valid_r || out_ready)) |=> out_valid_r && (state_r == S_IDLE))
    else $error("finished result not loaded");
`endif

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for seconds_to_calendar_split_top: drives second counts
// under several epoch/zone settings and checks every calendar field against an
// in-bench calendar computation. Depends on stc_pkg and the splitter RTL.
module tb_top;
  import stc_pkg::*;

  typedef struct {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [8:0]  day_of_year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } calendar_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [11:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [33:0] in_seconds_count;
  logic        out_valid;
  logic        out_ready;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day_of_month;
  logic [8:0]  out_day_of_year;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [2:0]  out_weekday;

  logic [33:0]       counts_queued[$];
  calendar_t         dates_due[$];
  logic [11:0]       epoch_mirror;
  logic signed [4:0] zone_mirror;
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  int unsigned       field_errors;

  // 1970 epoch landmarks: day, year, leap-day and century boundaries, bit patterns
  logic [33:0] landmark_secs[19] = '{
    34'd0, 34'd1, 34'd59, 34'd60, 34'd3599, 34'd3600, 34'd86399, 34'd86400,
    34'd31535999, 34'd31536000, 34'd68169600, 34'd94694399, 34'd951782400,
    34'd4107542399, 34'd4107542400, 34'h3FFFFFFFF, 34'h200000000,
    34'h2AAAAAAAA, 34'h155555555
  };

  seconds_to_calendar_split_top #(.SECONDS_WIDTH(34)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_seconds_count (in_seconds_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_day_of_year  (out_day_of_year),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .out_weekday      (out_weekday)
  );

  function automatic bit leap_year(input longint y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic longint month_days(input longint m, input bit lp);
    longint n;
    case (m)
      2: begin
        n = lp ? 29 : 28;
      end
      4, 6, 9, 11: begin
        n = 30;
      end
      default: begin
        n = 31;
      end
    endcase
    return n;
  endfunction

  function automatic calendar_t split_seconds(input logic [33:0] secs,
                                              input logic [11:0] epoch,
                                              input logic signed [4:0] zone);
    calendar_t c;
    longint    t;
    longint    days;
    longint    tod;
    longint    yr;
    longint    mon;
    longint    ylen;
    longint    wy;
    longint    wm;
    longint    wd;
    bit        lp;
    t = longint'(secs) + longint'(zone) * 3600;
    if (t < 0) begin
      t = 0;
    end
    days = t / 86400;
    tod = t % 86400;
    yr = longint'(epoch);
    forever begin
      ylen = leap_year(yr) ? 366 : 365;
      if (days < ylen) begin
        break;
      end
      days -= ylen;
      yr++;
    end
    c.day_of_year = 9'(days);
    lp = leap_year(yr);
    mon = 1;
    while (mon < 12 && days >= month_days(mon, lp)) begin
      days -= month_days(mon, lp);
      mon++;
    end
    c.year = 12'(yr);
    c.month = 4'(mon);
    c.day_of_month = 5'(days + 1);
    c.hour = 5'(tod / 3600);
    c.minute = 6'((tod % 3600) / 60);
    c.second = 6'(tod % 60);
    // Larsen, shifted by 400 years to keep the terms non-negative
    wy = yr + 400;
    wm = mon;
    wd = days + 1;
    if (wm <= 2) begin
      wm += 12;
      wy -= 1;
    end
    c.weekday = 3'((wd + 2 * wm + (3 * (wm + 1)) / 5 + wy + wy / 4 - wy / 100 + wy / 400) % 7);
    return c;
  endfunction

  function automatic logic [33:0] random_seconds();
    logic [33:0] v;
    longint      d;
    d = longint'($urandom_range(198000));
    case ($urandom_range(9))
      0, 1, 2: begin
        v = {2'($urandom_range(3)), 32'($urandom())};
      end
      3, 4: begin
        case ($urandom_range(2))
          0: begin
            v = 34'(d * 86400);
          end
          1: begin
            v = 34'(d * 86400 + 86399);
          end
          default: begin
            v = 34'(d * 86400 + longint'($urandom_range(86399)));
          end
        endcase
      end
      5, 6: begin
        v = 34'($urandom_range(32'h3FFFFFF));
      end
      7: begin
        v = 34'($urandom_range(200000));
      end
      8: begin
        v = ~34'($urandom_range(100000));
      end
      default: begin
        v = 34'($urandom_range(32'd946080000));
      end
    endcase
    return v;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      field_errors++;
    end
  endtask

  task automatic write_reg(input logic idx, input logic [11:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (counts_queued.size() != 0 || in_valid || dates_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #16000000;
    $display("tb: failure");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) begin
        dates_due.push_back(split_seconds(in_seconds_count, epoch_mirror, zone_mirror));
      end
      if (counts_queued.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_seconds_count <= counts_queued.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (dates_due.size() == 0) begin
        $error("unexpected transaction on result channel");
        field_errors++;
      end else begin
        calendar_t want;
        want = dates_due.pop_front();
        check_field("year", want.year, out_year);
        check_field("month", want.month, out_month);
        check_field("day_of_month", want.day_of_month, out_day_of_month);
        check_field("day_of_year", want.day_of_year, out_day_of_year);
        check_field("hour", want.hour, out_hour);
        check_field("minute", want.minute, out_minute);
        check_field("second", want.second, out_second);
        check_field("weekday", want.weekday, out_weekday);
      end
    end
  end

  initial begin
    int unsigned       epochs[6];
    int                zones[6];
    logic [33:0]       edge_secs[4];
    epochs = '{1970, 1600, 2400, 0, 4095, 0};
    zones = '{0, -12, 14, -16, 15, 0};
    edge_secs = '{34'd0, 34'd3599, 34'd43199, 34'h3FFFFFFFF};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_EPOCH_YEAR;
    cfg_wdata = 12'd0;
    in_valid = 1'b0;
    in_seconds_count = 34'd0;
    out_ready = 1'b0;
    epoch_mirror = 12'd1970;
    zone_mirror = 5'sd0;
    send_idle_pct = 25;
    recv_idle_pct = 79;
    field_errors = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 79;
        recv_idle_pct = 25;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 0) begin
        foreach (landmark_secs[i]) counts_queued.push_back(landmark_secs[i]);
      end else begin
        if (p == 5) begin
          epochs[p] = $urandom_range(4095);
          zones[p] = int'($urandom_range(31)) - 16;
        end
        write_reg(CFG_EPOCH_YEAR, 12'(epochs[p]));
        write_reg(CFG_ZONE_OFFSET, 12'(zones[p]));
        epoch_mirror = 12'(epochs[p]);
        zone_mirror = 5'(zones[p]);
        foreach (edge_secs[i]) counts_queued.push_back(edge_secs[i]);
      end
      repeat (155) counts_queued.push_back(random_seconds());
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (field_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
src/stc_pkg.sv
src/stc_alu.sv
src/seconds_to_calendar_split_top.sv
tb/sv/tb_top.sv
